// ===== rtl/ordered_list_with_key_delete_top_assert.svh =====
// Assertion macros for the ordered list block.
`ifndef ORDERED_LIST_WITH_KEY_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_WITH_KEY_DELETE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OLKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OLKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/olkd_pkg.sv =====
package olkd_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OPC_W    = 3;
    localparam int ST_W     = 3;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Raw opcodes as they arrive on the request channel
    localparam logic [OPC_W-1:0] OPC_INSERT    = 3'd0;
    localparam logic [OPC_W-1:0] OPC_DEL_KEY   = 3'd1;
    localparam logic [OPC_W-1:0] OPC_DEL_FIRST = 3'd2;
    localparam logic [OPC_W-1:0] OPC_DEL_LAST  = 3'd3;
    localparam logic [OPC_W-1:0] OPC_DUMP      = 3'd4;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DEL_KEY,
        OP_DEL_FIRST,
        OP_DEL_LAST,
        OP_DUMP,
        OP_NOP
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE     = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_ENTRY    = 3'd4
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_front_out;

endpackage

// ===== rtl/olkd_front.sv =====
module olkd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [olkd_pkg::OPC_W-1:0]         i_opcode,
    input  logic signed [olkd_pkg::KEY_W-1:0]  i_key,
    input  logic                               i_pop,
    output olkd_pkg::t_front_out               o_head
);

    olkd_pkg::t_cmd                     r_q [olkd_pkg::QDEPTH];
    logic [olkd_pkg::QPTR_W-1:0]        r_wr;
    logic [olkd_pkg::QPTR_W-1:0]        r_rd;
    logic [olkd_pkg::QCNT_W-1:0]        r_cnt;
    logic [olkd_pkg::QCNT_W-1:0]        n_cnt;
    olkd_pkg::t_cmd                     n_cmd;
    logic                               push;
    logic                               pop;

    // Classify the opcode; unused codes become a no-op
    always_comb begin
        n_cmd.key = i_key;
        case (i_opcode)
            olkd_pkg::OPC_INSERT:    n_cmd.op = olkd_pkg::OP_INSERT;
            olkd_pkg::OPC_DEL_KEY:   n_cmd.op = olkd_pkg::OP_DEL_KEY;
            olkd_pkg::OPC_DEL_FIRST: n_cmd.op = olkd_pkg::OP_DEL_FIRST;
            olkd_pkg::OPC_DEL_LAST:  n_cmd.op = olkd_pkg::OP_DEL_LAST;
            olkd_pkg::OPC_DUMP:      n_cmd.op = olkd_pkg::OP_DUMP;
            default:                 n_cmd.op = olkd_pkg::OP_NOP;
        endcase
    end

    assign o_in_stall = (r_cnt == olkd_pkg::QCNT_W'(olkd_pkg::QDEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + olkd_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - olkd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= r_wr + olkd_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + olkd_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];

endmodule

// ===== rtl/olkd_back.sv =====
module olkd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  olkd_pkg::t_front_out               i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [olkd_pkg::ST_W-1:0]          o_status,
    output logic signed [olkd_pkg::KEY_W-1:0]  o_entry_key,
    output logic                               o_last,
    output logic [olkd_pkg::CNT_W-1:0]         o_occupancy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [olkd_pkg::KEY_W-1:0]          r_cell [olkd_pkg::CAPACITY];
    logic [olkd_pkg::KEY_W-1:0]          n_cell [olkd_pkg::CAPACITY];
    logic [olkd_pkg::CNT_W-1:0]          r_count;
    logic [olkd_pkg::CNT_W-1:0]          n_count;
    logic [olkd_pkg::IDX_W-1:0]          r_pos;
    logic [olkd_pkg::IDX_W-1:0]          n_pos;
    logic                                r_out_valid;
    olkd_pkg::t_status                   r_status;
    logic [olkd_pkg::KEY_W-1:0]          r_entry_key;
    logic                                r_last;
    logic [olkd_pkg::CNT_W-1:0]          r_occupancy;
    logic                                n_emit;
    olkd_pkg::t_status                   n_status;
    logic [olkd_pkg::KEY_W-1:0]          n_entry_key;
    logic                                n_last;
    logic [olkd_pkg::CAPACITY-1:0]       hit;
    logic [olkd_pkg::CAPACITY-1:0]       shift_dn;
    logic                                found;
    logic                                empty;
    logic                                full;
    logic                                out_free;
    logic                                take;
    logic                                dump_last;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign take      = (r_state == S_IDLE) && i_head.valid && out_free;
    assign o_pop     = take;
    assign empty     = (r_count == '0);
    assign full      = (r_count == olkd_pkg::CNT_W'(olkd_pkg::CAPACITY));
    assign dump_last = (olkd_pkg::CNT_W'(r_pos) == r_count - olkd_pkg::CNT_W'(1));

    // Every live cell compares against the key at once
    always_comb begin
        for (int i = 0; i < olkd_pkg::CAPACITY; i++) begin
            hit[i] = (r_cell[i] == i_head.cmd.key) && (r_count > olkd_pkg::CNT_W'(i));
        end
        for (int i = 0; i < olkd_pkg::CAPACITY; i++) begin
            shift_dn[i] = |(hit & ~({olkd_pkg::CAPACITY{1'b1}} << (i + 1)));
        end
    end
    assign found = |hit;

    always_comb begin
        n_cell      = r_cell;
        n_count     = r_count;
        n_state     = r_state;
        n_pos       = r_pos;
        n_emit      = 1'b0;
        n_status    = olkd_pkg::ST_DONE;
        n_entry_key = '0;
        n_last      = 1'b1;
        if (take) begin
            n_emit = 1'b1;
            case (i_head.cmd.op)
                olkd_pkg::OP_INSERT: begin
                    if (full) begin
                        n_status = olkd_pkg::ST_FULL;
                    end else begin
                        n_cell[0] = i_head.cmd.key;
                        for (int i = 1; i < olkd_pkg::CAPACITY; i++) begin
                            n_cell[i] = r_cell[i-1];
                        end
                        n_count = r_count + olkd_pkg::CNT_W'(1);
                    end
                end
                olkd_pkg::OP_DEL_KEY: begin
                    if (empty) begin
                        n_status = olkd_pkg::ST_EMPTY;
                    end else if (!found) begin
                        n_status = olkd_pkg::ST_NOTFOUND;
                    end else begin
                        // close the gap from the first match onwards
                        for (int i = 0; i < olkd_pkg::CAPACITY - 1; i++) begin
                            if (shift_dn[i]) begin
                                n_cell[i] = r_cell[i+1];
                            end
                        end
                        n_count = r_count - olkd_pkg::CNT_W'(1);
                    end
                end
                olkd_pkg::OP_DEL_FIRST: begin
                    if (empty) begin
                        n_status = olkd_pkg::ST_EMPTY;
                    end else begin
                        for (int i = 0; i < olkd_pkg::CAPACITY - 1; i++) begin
                            n_cell[i] = r_cell[i+1];
                        end
                        n_count = r_count - olkd_pkg::CNT_W'(1);
                    end
                end
                olkd_pkg::OP_DEL_LAST: begin
                    if (empty) begin
                        n_status = olkd_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - olkd_pkg::CNT_W'(1);
                    end
                end
                olkd_pkg::OP_DUMP: begin
                    if (empty) begin
                        n_status = olkd_pkg::ST_EMPTY;
                    end else begin
                        // enter the dump state, which walks the cells
                        n_emit  = 1'b0;
                        n_state = S_DUMP;
                        n_pos   = '0;
                    end
                end
                default: begin
                end
            endcase
        end else if ((r_state == S_DUMP) && out_free) begin
            n_emit      = 1'b1;
            n_status    = olkd_pkg::ST_ENTRY;
            n_entry_key = r_cell[r_pos];
            n_last      = dump_last;
            if (dump_last) begin
                n_state = S_IDLE;
                n_pos   = '0;
            end else begin
                n_pos = r_pos + olkd_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            if (out_free) begin
                r_out_valid <= n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (out_free && n_emit) begin
            r_status    <= n_status;
            r_entry_key <= n_entry_key;
            r_last      <= n_last;
            r_occupancy <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_entry_key = r_entry_key;
    assign o_last      = r_last;
    assign o_occupancy = r_occupancy;

endmodule

// ===== rtl/ordered_list_with_key_delete_top.sv =====
// Ordered list of signed 32-bit keys, held front to back in a row of cells.
// Request channel: i_in_valid / o_in_stall with i_opcode and i_key. Opcodes:
// insert at front, delete first match of a key, delete first, delete last, dump.
// Result channel: o_out_valid / i_out_stall with o_status, o_entry_key, o_last
// and o_occupancy (entries held after the request).
// A request sits in a two-deep queue; the cell row takes one from it per cycle
// while not dumping and the result register is free. Insert and the deletes
// compare and shift every cell at once, the request passing the queue entry and
// then the result register; they sustain one per cycle unless the receiver stalls.
// A dump first enters its walk state with no result, then gives its entries front
// to back with o_last on the final entry; an empty dump gives one empty status.
// Every other request gives exactly one result with o_last set.
// Reset empties the list and the queue. When the receiver stalls, the result
// register holds; the cell row waits and the queue fills, then o_in_stall rises.
module ordered_list_with_key_delete_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [olkd_pkg::OPC_W-1:0]         i_opcode,
    input  logic signed [olkd_pkg::KEY_W-1:0]  i_key,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [olkd_pkg::ST_W-1:0]          o_status,
    output logic signed [olkd_pkg::KEY_W-1:0]  o_entry_key,
    output logic                               o_last,
    output logic [olkd_pkg::CNT_W-1:0]         o_occupancy
);

    olkd_pkg::t_front_out head;
    logic                 pop;

    olkd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_key      (i_key),
        .i_pop      (pop),
        .o_head     (head)
    );

    olkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_entry_key (o_entry_key),
        .o_last      (o_last),
        .o_occupancy (o_occupancy)
    );

`include "ordered_list_with_key_delete_top_assert.svh"

    `OLKD_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, o_out_valid,
        o_occupancy <= olkd_pkg::CNT_W'(olkd_pkg::CAPACITY), "occupancy beyond capacity")

    `OLKD_ASSERT_NOW(a_full_occ, i_clk, i_rst_n, o_out_valid && (o_status == olkd_pkg::ST_FULL),
        o_occupancy == olkd_pkg::CNT_W'(olkd_pkg::CAPACITY), "full status on a list with room")

    `OLKD_ASSERT_NOW(a_status_key, i_clk, i_rst_n, o_out_valid && (o_status != olkd_pkg::ST_ENTRY),
        o_last && (o_entry_key == '0), "status result not final or carries a key")

    `OLKD_ASSERT_NEXT(a_pop_valid, i_clk, i_rst_n, pop && !head.valid,
        1'b0, "pop from an empty queue")

endmodule

// ===== tb/ordered_list_with_key_delete_top_test.sv =====
module ordered_list_with_key_delete_top_test;

    localparam int CAPACITY       = olkd_pkg::CAPACITY;
    localparam int KEY_W          = olkd_pkg::KEY_W;
    localparam int OPC_W          = olkd_pkg::OPC_W;
    localparam int ST_W           = olkd_pkg::ST_W;
    localparam int CNT_W          = olkd_pkg::CNT_W;
    localparam int MAX_GAP        = 17;
    localparam int RANDOM_ITEMS   = 440;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIRECTED_ROWS  = 20;

    // Opcodes with no operation behind them
    localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd5;
    localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_NEG1 = '1;

    typedef struct packed {
        olkd_pkg::t_status        status;
        logic signed [KEY_W-1:0]  entry_key;
        logic                     last;
        logic [CNT_W-1:0]         occupancy;
    } t_list_result;

    typedef struct packed {
        logic [OPC_W-1:0]         op;
        logic signed [KEY_W-1:0]  key;
        bit                       typed;
        olkd_pkg::t_status        status;
        int                       occupancy;
    } t_directed_row;

    typedef enum {EP_FILL, EP_DRAIN, EP_MIXED} t_episode;

    // Typed rows carry a status result with last set and a zero key
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{olkd_pkg::OPC_DUMP,      32'h0,        1'b1, olkd_pkg::ST_EMPTY,    0},
        '{olkd_pkg::OPC_DEL_KEY,   32'h5,        1'b1, olkd_pkg::ST_EMPTY,    0},
        '{olkd_pkg::OPC_DEL_FIRST, 32'hFFFFFFFF, 1'b1, olkd_pkg::ST_EMPTY,    0},
        '{olkd_pkg::OPC_DEL_LAST,  32'h0,        1'b1, olkd_pkg::ST_EMPTY,    0},
        '{OPC_SPARE_LO,            KEY_MAX,      1'b1, olkd_pkg::ST_DONE,     0},
        '{OPC_SPARE_HI,            KEY_MIN,      1'b1, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_INSERT,    KEY_MAX,      1'b1, olkd_pkg::ST_DONE,     1},
        '{olkd_pkg::OPC_INSERT,    KEY_MIN,      1'b1, olkd_pkg::ST_DONE,     2},
        '{olkd_pkg::OPC_INSERT,    32'h0,        1'b1, olkd_pkg::ST_DONE,     3},
        '{olkd_pkg::OPC_INSERT,    KEY_NEG1,     1'b1, olkd_pkg::ST_DONE,     4},
        '{olkd_pkg::OPC_DUMP,      32'hA5A5A5A5, 1'b0, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_DEL_KEY,   32'd1234,     1'b1, olkd_pkg::ST_NOTFOUND, 4},
        '{olkd_pkg::OPC_DEL_KEY,   KEY_MIN,      1'b1, olkd_pkg::ST_DONE,     3},
        '{olkd_pkg::OPC_INSERT,    KEY_NEG1,     1'b0, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_DEL_KEY,   KEY_NEG1,     1'b0, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_DEL_FIRST, 32'h5A5A5A5A, 1'b0, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_DEL_LAST,  KEY_MAX,      1'b0, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_DUMP,      32'h0,        1'b0, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_DEL_FIRST, 32'h0,        1'b0, olkd_pkg::ST_DONE,     0},
        '{olkd_pkg::OPC_DUMP,      KEY_NEG1,     1'b1, olkd_pkg::ST_EMPTY,    0}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [OPC_W-1:0]         i_opcode = '0;
    logic signed [KEY_W-1:0]  i_key = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [ST_W-1:0]          o_status;
    logic signed [KEY_W-1:0]  o_entry_key;
    logic                     o_last;
    logic [CNT_W-1:0]         o_occupancy;

    logic signed [KEY_W-1:0]  held_keys[$];
    t_list_result             pending_results[$];
    int                       error_count = 0;
    int                       idle_cycles = 0;
    bit                       in_quiet = 1'b0;
    bit                       out_quiet = 1'b0;

    ordered_list_with_key_delete_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_entry_key (o_entry_key),
        .o_last      (o_last),
        .o_occupancy (o_occupancy)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Apply one request to the list copy and return the results it causes
    task automatic apply_list_command(input logic [OPC_W-1:0] op,
                                      input logic signed [KEY_W-1:0] key,
                                      output t_list_result outs[$]);
        int                hit;
        int                count;
        olkd_pkg::t_status st;
        outs  = {};
        st    = olkd_pkg::ST_DONE;
        count = held_keys.size();
        case (op)
            olkd_pkg::OPC_INSERT: begin
                if (count >= CAPACITY)
                    st = olkd_pkg::ST_FULL;
                else
                    held_keys.push_front(key);
            end
            olkd_pkg::OPC_DEL_KEY: begin
                if (count == 0) begin
                    st = olkd_pkg::ST_EMPTY;
                end else begin
                    hit = -1;
                    foreach (held_keys[i])
                        if (hit < 0 && held_keys[i] == key)
                            hit = i;
                    if (hit < 0)
                        st = olkd_pkg::ST_NOTFOUND;
                    else
                        held_keys.delete(hit);
                end
            end
            olkd_pkg::OPC_DEL_FIRST: begin
                if (count == 0)
                    st = olkd_pkg::ST_EMPTY;
                else
                    void'(held_keys.pop_front());
            end
            olkd_pkg::OPC_DEL_LAST: begin
                if (count == 0)
                    st = olkd_pkg::ST_EMPTY;
                else
                    void'(held_keys.pop_back());
            end
            olkd_pkg::OPC_DUMP: begin
                if (count == 0) begin
                    st = olkd_pkg::ST_EMPTY;
                end else begin
                    foreach (held_keys[i])
                        outs.push_back('{olkd_pkg::ST_ENTRY, held_keys[i], (i == count - 1),
                                         CNT_W'(count)});
                    return;
                end
            end
            default: ;
        endcase
        outs.push_back('{st, '0, 1'b1, CNT_W'(held_keys.size())});
    endtask

    task automatic send_request(input logic [OPC_W-1:0] op,
                                input logic signed [KEY_W-1:0] key,
                                input bit typed,
                                input t_list_result typed_result);
        int           gap;
        t_list_result outs[$];
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        apply_list_command(op, key, outs);
        if (typed)
            pending_results.push_back(typed_result);
        else
            foreach (outs[i])
                pending_results.push_back(outs[i]);
        @(negedge i_clk);
    endtask

    function automatic logic [OPC_W-1:0] pick_opcode(input t_episode ep);
        int roll;
        roll = $urandom_range(0, 99);
        case (ep)
            EP_FILL: begin
                if (roll < 88) return olkd_pkg::OPC_INSERT;
                if (roll < 97) return olkd_pkg::OPC_DUMP;
                return olkd_pkg::OPC_DEL_KEY;
            end
            EP_DRAIN: begin
                if (roll < 30) return olkd_pkg::OPC_DEL_KEY;
                if (roll < 55) return olkd_pkg::OPC_DEL_FIRST;
                if (roll < 80) return olkd_pkg::OPC_DEL_LAST;
                if (roll < 90) return olkd_pkg::OPC_INSERT;
                if (roll < 97) return olkd_pkg::OPC_DUMP;
                return OPC_W'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI));
            end
            default: begin
                if (roll < 40) return olkd_pkg::OPC_INSERT;
                if (roll < 60) return olkd_pkg::OPC_DEL_KEY;
                if (roll < 72) return olkd_pkg::OPC_DEL_FIRST;
                if (roll < 84) return olkd_pkg::OPC_DEL_LAST;
                if (roll < 96) return olkd_pkg::OPC_DUMP;
                return OPC_W'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI));
            end
        endcase
    endfunction

    // Favour keys already held for deletes, and a narrow range so duplicates occur
    function automatic logic signed [KEY_W-1:0] pick_key(input logic [OPC_W-1:0] op);
        int roll;
        roll = $urandom_range(0, 99);
        if (op == olkd_pkg::OPC_DEL_KEY && held_keys.size() != 0 && roll < 70)
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return KEY_W'($urandom_range(0, 15)) - KEY_W'(8);
        if (roll < 55) begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_NEG1;
                default: return '0;
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        int               sent;
        int               len;
        bit               first;
        t_episode         ep;
        logic [OPC_W-1:0] op;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].typed,
                         '{directed_rows[r].status, '0, 1'b1,
                           CNT_W'(directed_rows[r].occupancy)});

        // Random part in episodes; open with a fill so the full list is reached early
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (first) begin
                ep = EP_FILL;
            end else begin
                case ($urandom_range(0, 2))
                    0: ep = EP_FILL;
                    1: ep = EP_DRAIN;
                    default: ep = EP_MIXED;
                endcase
            end
            len       = (ep == EP_FILL) ? CAPACITY + 8 : $urandom_range(10, 40);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            first     = 1'b0;
            for (int n = 0; n < len && sent < RANDOM_ITEMS; n++) begin
                op = pick_opcode(ep);
                send_request(op, pick_key(op), 1'b0, '0);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: hold off each result for a random number of cycles
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d, key 0x%0h",
                       o_status, o_entry_key);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", KEY_W'(want.status), KEY_W'(o_status));
                check_field("entry_key", want.entry_key, o_entry_key);
                check_field("last", KEY_W'(want.last), KEY_W'(o_last));
                check_field("occupancy", KEY_W'(want.occupancy), KEY_W'(o_occupancy));
            end
        end
    end

    // Abort if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/olkd_pkg.sv
rtl/olkd_front.sv
rtl/olkd_back.sv
rtl/ordered_list_with_key_delete_top.sv
tb/ordered_list_with_key_delete_top_test.sv
